>>> rtl/first_fit_unit_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// first_fit_unit_allocator_top_macros.svh
// Assertion macros used by the allocator top level.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_UNIT_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_UNIT_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define FFUA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define FFUA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/ffua_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffua_pkg
// Constants, codes and controller/datapath interface types of the allocator.
// ----------------------------------------------------------------------------
package ffua_pkg;

    localparam int UNITS      = 1024;
    localparam int OWNER_BITS = 8;

    localparam int UNIT_W  = $clog2(UNITS);
    localparam int COUNT_W = $clog2(UNITS + 1);

    // Field widths of the stream items.
    localparam int FUNC_W     = 1;
    localparam int SIZE_W     = 11;
    localparam int OWNER_ID_W = 8;
    localparam int ADDR_W     = 10;
    localparam int STATUS_W   = 2;
    localparam int START_W    = 10;
    localparam int FREE_W     = 11;
    localparam int RES_W      = 11;
    localparam int CFG_W      = 11;

    localparam logic [CFG_W-1:0] UPP_RESET = CFG_W'(64);

    // Input item layout inside s_tdata.
    localparam int S_SIZE_LSB  = 0;
    localparam int S_OWNER_LSB = S_SIZE_LSB + SIZE_W;
    localparam int S_ADDR_LSB  = S_OWNER_LSB + OWNER_ID_W;
    localparam int S_TDATA_W   = ((S_ADDR_LSB + ADDR_W + 7) / 8) * 8;

    // Result item layout inside m_tdata.
    localparam int M_START_LSB = 0;
    localparam int M_FREE_LSB  = M_START_LSB + START_W;
    localparam int M_RES_LSB   = M_FREE_LSB + FREE_W;
    localparam int M_TDATA_W   = ((M_RES_LSB + RES_W + 7) / 8) * 8;

    // Width that holds every size, address and count without overflow.
    localparam int FIELD_MAX_W = (SIZE_W > ADDR_W) ? SIZE_W : ADDR_W;
    localparam int WIDE_W      = ((COUNT_W > FIELD_MAX_W) ? COUNT_W : FIELD_MAX_W) + 1;

    // Divider step counter.
    localparam int DIV_STEP_W = $clog2(COUNT_W + 1);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_NOT_OWNED = 2'd2,
        ST_BAD_REQ   = 2'd3
    } res_status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MARK,
        S_FREAD,
        S_FCHECK,
        S_WALK,
        S_WTAIL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_LOAD,
        OP_SCAN,
        OP_MARK,
        OP_FREAD,
        OP_WALK,
        OP_WTAIL,
        OP_DIV,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        logic        set_status;
        res_status_t status;
    } ffua_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic req_free;
        logic req_bad;
        logic addr_outside;
        logic scan_hit;
        logic scan_miss;
        logic mark_last;
        logic owned;
        logic walk_last;
        logic div_done;
        logic out_free;
    } ffua_stat_t;

endpackage

>>> rtl/ffua_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffua_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ffua_div import ffua_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [COUNT_W-1:0] dividend,
    input  logic [CFG_W-1:0]   divisor,
    output logic               done,
    output logic [COUNT_W-1:0] quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [COUNT_W-1:0]    quo_reg, quo_next;
    logic [CFG_W-1:0]      rem_reg, rem_next;
    logic [CFG_W-1:0]      dvsr_reg, dvsr_next;
    logic [CFG_W:0]        shifted;
    logic [CFG_W:0]        diff;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[COUNT_W-1]};
    assign diff    = shifted - {1'b0, dvsr_reg};
    assign fits    = shifted >= {1'b0, dvsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = DIV_STEP_W'(COUNT_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[COUNT_W-2:0], fits};
            rem_next  = fits ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
            step_next = step_reg - DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/ffua_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffua_dp
// Datapath: owner map memory, request registers, counters, divider and result register.
// ----------------------------------------------------------------------------
module ffua_dp import ffua_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  ffua_cmd_t            cmd,
    output ffua_stat_t           stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]  m_tuser
);

    // Owner map, one entry per unit, zero meaning free.
    logic [OWNER_BITS-1:0] owner_mem [UNITS];
    logic [OWNER_BITS-1:0] rd_data_reg;
    logic                  mem_we;
    logic [OWNER_BITS-1:0] mem_wdata;

    logic                  func_reg, func_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [OWNER_BITS-1:0] owner_reg, owner_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [COUNT_W-1:0]    ptr_reg, ptr_next;
    logic [COUNT_W-1:0]    end_reg, end_next;
    logic [COUNT_W-1:0]    run_reg, run_next;
    logic [COUNT_W-1:0]    rem_reg, rem_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [UNIT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [COUNT_W-1:0]    used_reg, used_next;
    logic [CFG_W-1:0]      upp_reg, upp_next;
    res_status_t           res_status_reg, res_status_next;
    logic [UNIT_W-1:0]     res_start_reg, res_start_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]   m_tuser_reg, m_tuser_next;

    logic [CFG_W-1:0]      per_proc;
    logic [WIDE_W-1:0]     size_w;
    logic [WIDE_W-1:0]     end_sum;
    logic [WIDE_W-1:0]     start_w;
    logic                  unit_free;
    logic                  div_done;
    logic [COUNT_W-1:0]    quotient;
    logic [COUNT_W-1:0]    free_count;

    assign per_proc   = (upp_reg == '0) ? CFG_W'(1) : upp_reg;
    assign size_w     = WIDE_W'(size_reg);
    assign end_sum    = WIDE_W'(addr_reg) + WIDE_W'(per_proc);
    assign start_w    = WIDE_W'(rd_idx_reg) + WIDE_W'(1) - size_w;
    assign unit_free  = (rd_data_reg == '0);
    assign free_count = COUNT_W'(UNITS) - used_reg;

    always_comb begin
        stat.clear_last   = (ptr_reg == COUNT_W'(UNITS - 1));
        stat.req_free     = (func_reg == FUNC_FREE);
        stat.req_bad      = (size_w == '0) || (size_w > WIDE_W'(UNITS)) || (owner_reg == '0);
        stat.addr_outside = (WIDE_W'(addr_reg) >= WIDE_W'(UNITS));
        stat.scan_hit     = rd_vld_reg && unit_free
                            && (WIDE_W'(run_reg) + WIDE_W'(1) == size_w);
        stat.scan_miss    = rd_vld_reg && !stat.scan_hit
                            && (rd_idx_reg == UNIT_W'(UNITS - 1));
        stat.mark_last    = (rem_reg == COUNT_W'(1));
        stat.owned        = !unit_free;
        stat.walk_last    = (WIDE_W'(ptr_reg) + WIDE_W'(1) == WIDE_W'(end_reg));
        stat.div_done     = div_done;
        stat.out_free     = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        func_next       = func_reg;
        size_next       = size_reg;
        owner_next      = owner_reg;
        addr_next       = addr_reg;
        ptr_next        = ptr_reg;
        end_next        = end_reg;
        run_next        = run_reg;
        rem_next        = rem_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        used_next       = used_reg;
        upp_next        = cfg_wr_en ? cfg_wr_data : upp_reg;
        res_status_next = cmd.set_status ? cmd.status : res_status_reg;
        res_start_next  = res_start_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        mem_we          = 1'b0;
        mem_wdata       = '0;

        unique case (cmd.op)
            OP_HOLD: begin
            end
            OP_CLEAR: begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + COUNT_W'(1);
            end
            OP_LOAD: begin
                func_next      = s_tuser;
                size_next      = s_tdata[S_SIZE_LSB +: SIZE_W];
                owner_next     = OWNER_BITS'(s_tdata[S_OWNER_LSB +: OWNER_ID_W]);
                addr_next      = s_tdata[S_ADDR_LSB +: ADDR_W];
                ptr_next       = (s_tuser == FUNC_FREE)
                                 ? COUNT_W'(s_tdata[S_ADDR_LSB +: ADDR_W]) : '0;
                run_next       = '0;
                res_start_next = '0;
            end
            OP_SCAN: begin
                if (rd_vld_reg) begin
                    run_next = unit_free ? run_reg + COUNT_W'(1) : '0;
                end
                if (stat.scan_hit) begin
                    res_start_next = start_w[UNIT_W-1:0];
                    ptr_next       = COUNT_W'(start_w);
                    rem_next       = COUNT_W'(size_reg);
                end else if (ptr_reg < COUNT_W'(UNITS)) begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[UNIT_W-1:0];
                    ptr_next    = ptr_reg + COUNT_W'(1);
                end
            end
            OP_MARK: begin
                mem_we    = 1'b1;
                mem_wdata = owner_reg;
                ptr_next  = ptr_reg + COUNT_W'(1);
                rem_next  = rem_reg - COUNT_W'(1);
                if (stat.mark_last) begin
                    used_next = used_reg + COUNT_W'(size_reg);
                end
            end
            OP_FREAD: begin
                end_next = (end_sum > WIDE_W'(UNITS)) ? COUNT_W'(UNITS) : COUNT_W'(end_sum);
            end
            OP_WALK: begin
                // The read of a unit sees its value before this cycle's clearing write.
                mem_we      = 1'b1;
                rd_vld_next = 1'b1;
                ptr_next    = ptr_reg + COUNT_W'(1);
                if (rd_vld_reg && !unit_free) begin
                    used_next = used_reg - COUNT_W'(1);
                end
            end
            OP_WTAIL: begin
                if (rd_vld_reg && !unit_free) begin
                    used_next = used_reg - COUNT_W'(1);
                end
            end
            OP_DIV: begin
            end
            OP_OUT: begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = '0;
                m_tdata_next[M_START_LSB +: START_W] =
                    (res_status_reg == ST_DONE && func_reg == FUNC_ALLOC)
                    ? START_W'(res_start_reg) : '0;
                m_tdata_next[M_FREE_LSB +: FREE_W] = FREE_W'(free_count);
                m_tdata_next[M_RES_LSB +: RES_W]   = RES_W'(quotient);
                m_tuser_next  = res_status_reg;
            end
            default: begin
            end
        endcase
    end

    ffua_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == OP_DIV),
        .dividend (used_reg),
        .divisor  (per_proc),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            owner_mem[ptr_reg[UNIT_W-1:0]] <= mem_wdata;
        end
        rd_data_reg <= owner_mem[ptr_reg[UNIT_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg        <= '0;
            end_reg        <= '0;
            run_reg        <= '0;
            rem_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            used_reg       <= '0;
            upp_reg        <= UPP_RESET;
            res_status_reg <= ST_DONE;
            m_tvalid_reg   <= 1'b0;
        end else begin
            ptr_reg        <= ptr_next;
            end_reg        <= end_next;
            run_reg        <= run_next;
            rem_reg        <= rem_next;
            rd_vld_reg     <= rd_vld_next;
            used_reg       <= used_next;
            upp_reg        <= upp_next;
            res_status_reg <= res_status_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        func_reg      <= func_next;
        size_reg      <= size_next;
        owner_reg     <= owner_next;
        addr_reg      <= addr_next;
        rd_idx_reg    <= rd_idx_next;
        res_start_reg <= res_start_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/ffua_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffua_ctrl
// Controller state machine that sequences clear, allocate and free work.
// ----------------------------------------------------------------------------
module ffua_ctrl import ffua_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ffua_stat_t stat,
    output ffua_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd.op         = OP_HOLD;
        cmd.set_status = 1'b0;
        cmd.status     = ST_DONE;
        s_tready       = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (!stat.req_free && stat.req_bad) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_BAD_REQ;
                    state_next     = S_DIV_GO;
                end else if (!stat.req_free) begin
                    state_next = S_SCAN;
                end else if (stat.addr_outside) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_OWNED;
                    state_next     = S_DIV_GO;
                end else begin
                    state_next = S_FREAD;
                end
            end
            S_SCAN: begin
                cmd.op = OP_SCAN;
                priority if (stat.scan_hit) begin
                    state_next = S_MARK;
                end else if (stat.scan_miss) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NO_FIT;
                    state_next     = S_DIV_GO;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_MARK: begin
                cmd.op = OP_MARK;
                if (stat.mark_last) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_DONE;
                    state_next     = S_DIV_GO;
                end
            end
            S_FREAD: begin
                cmd.op     = OP_FREAD;
                state_next = S_FCHECK;
            end
            S_FCHECK: begin
                if (stat.owned) begin
                    state_next = S_WALK;
                end else begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_OWNED;
                    state_next     = S_DIV_GO;
                end
            end
            S_WALK: begin
                cmd.op = OP_WALK;
                if (stat.walk_last) begin
                    state_next = S_WTAIL;
                end
            end
            S_WTAIL: begin
                cmd.op         = OP_WTAIL;
                cmd.set_status = 1'b1;
                cmd.status     = ST_DONE;
                state_next     = S_DIV_GO;
            end
            S_DIV_GO: begin
                cmd.op     = OP_DIV;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (stat.div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/first_fit_unit_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_unit_allocator_top
// First-fit allocator of contiguous memory units with an owner map.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         s_tvalid/s_tready  request: func, size, owner, address
//   m_*       out        m_tvalid/m_tready  result: status, start, free, resident
//   cfg_*     in         cfg_wr_en          units_per_process
//
// After reset the owner map is cleared by a sweep over all UNITS (1024) units, one
// unit per cycle, during which no item is accepted.
// Items are handled one at a time. The time each takes is set by the unit-by-unit walk
// over the owner map and by the bit-serial divider for the resident count.
// A finished result waits in the output register while the next item is accepted;
// a stalled m_tready holds only the hand-off of the following result.
//
// The block takes one request at a time from the input stream. An allocate
// scans the owner map from unit 0, counting the current run of free units, and
// stops at the first run that reaches the requested size. It then writes the
// owner into that run. A free checks the addressed unit first and, if it is
// owned, clears a run of units_per_process units clipped to the end of memory,
// counting how many of them were owned. Both then divide the used unit count by
// units_per_process to report the resident process count.
module first_fit_unit_allocator_top import ffua_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request item.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0 up: request_size[10:0], owner_id[18:11],
    // free_address[28:19], zero padding.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Field: func (0 allocate, 1 free).
    input  logic                 s_tuser,
    // Result item.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0 up: start_unit[9:0], free_units[20:10],
    // resident_processes[31:21].
    output logic [M_TDATA_W-1:0] m_tdata,
    // Field: status.
    output logic [STATUS_W-1:0]  m_tuser,
    // units_per_process register write.
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

`include "first_fit_unit_allocator_top_macros.svh"

    ffua_cmd_t  cmd;
    ffua_stat_t stat;

    // The controller sequences the phases of each request.
    ffua_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the owner map, the counters and the result register.
    ffua_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // A request is worked on alone, so the input closes right after an accept.
    `FFUA_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "item accepted while another is in work")

    // Only a successful allocate reports a start unit.
    `FFUA_ASSERT_NOW(a_start_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_DONE), m_tdata[M_START_LSB +: START_W] == '0, "start unit set on a failed request")

    // The free unit count can never exceed the memory size.
    `FFUA_ASSERT_NOW(a_free_range, aclk, aresetn, m_tvalid, m_tdata[M_FREE_LSB +: FREE_W] <= FREE_W'(UNITS), "free unit count above memory size")

endmodule

>>> verif/first_fit_unit_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_unit_allocator_top_tb
// Self-checking bench for the first-fit unit allocator.
// ----------------------------------------------------------------------------
// A queue of request items feeds a clocked driver. A clocked monitor takes
// the result items. Each accepted request goes through a behavioral copy of
// the owner map, which gives the expected result. The bench starts with a
// directed run through the corner cases, then sends random batches. Between
// batches the units_per_process register is rewritten. Both the request side
// and the result side stall in short random bursts.
// ----------------------------------------------------------------------------
module first_fit_unit_allocator_top_tb;
    import ffua_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2100;
    localparam int BATCH_COUNT    = 28;
    localparam int BATCH_ITEMS    = 20;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] request_size;
        logic [OWNER_ID_W-1:0] owner_id;
        logic [ADDR_W-1:0] free_address;
    } alloc_request_t;

    typedef struct packed {
        res_status_t        status;
        logic [START_W-1:0] start_unit;
        logic [FREE_W-1:0]  free_units;
        logic [RES_W-1:0]   resident_processes;
    } alloc_result_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;

    // Model of the allocator state.
    logic [OWNER_BITS-1:0] unit_owner [UNITS];
    int                    used_count;
    logic [CFG_W-1:0]      run_length;

    alloc_request_t request_queue [$];
    alloc_result_t  expected_replies [$];
    alloc_request_t on_bus;
    int             issued_count   = 0;
    int             answered_count = 0;
    int             mismatches     = 0;
    int             quiet_cycles   = 0;
    int             send_gap       = 0;
    int             recv_gap       = 0;
    bit             stall_enable   = 1'b1;

    first_fit_unit_allocator_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    // Applies one request to the model and returns the result it produces.
    function automatic alloc_result_t apply_request(input alloc_request_t req);
        alloc_result_t r;
        int            i;
        int            run;
        int            first;
        int            stop;
        int            released;
        int            divisor;
        bit            found;
        r.status     = ST_DONE;
        r.start_unit = '0;
        divisor      = (run_length == 0) ? 1 : int'(run_length);
        if (req.func == FUNC_ALLOC) begin
            if (req.request_size == 0 || req.request_size > UNITS || req.owner_id == 0) begin
                r.status = ST_BAD_REQ;
            end else begin
                run   = 0;
                first = 0;
                found = 1'b0;
                for (i = 0; i < UNITS && !found; i++) begin
                    if (unit_owner[i] == 0) begin
                        run++;
                        if (run == int'(req.request_size)) begin
                            found = 1'b1;
                            first = i + 1 - int'(req.request_size);
                        end
                    end else begin
                        run = 0;
                    end
                end
                if (!found) begin
                    r.status = ST_NO_FIT;
                end else begin
                    for (i = first; i < first + int'(req.request_size); i++)
                        unit_owner[i] = req.owner_id;
                    used_count  += int'(req.request_size);
                    r.start_unit = first[START_W-1:0];
                end
            end
        end else begin
            if (unit_owner[req.free_address] == 0) begin
                r.status = ST_NOT_OWNED;
            end else begin
                // The freed run is clipped at the end of memory and may be only
                // partly owned; only owned units count against used_count.
                stop = int'(req.free_address) + divisor;
                if (stop > UNITS)
                    stop = UNITS;
                released = 0;
                for (i = int'(req.free_address); i < stop; i++) begin
                    if (unit_owner[i] != 0) begin
                        unit_owner[i] = '0;
                        released++;
                    end
                end
                used_count -= released;
            end
        end
        r.free_units         = FREE_W'(UNITS - used_count);
        r.resident_processes = RES_W'(used_count / divisor);
        return r;
    endfunction

    task automatic queue_request(input logic func, input int size, input int owner,
                                 input int addr);
        alloc_request_t req;
        req.func         = func;
        req.request_size = SIZE_W'(size);
        req.owner_id     = OWNER_ID_W'(owner);
        req.free_address = ADDR_W'(addr);
        request_queue.push_back(req);
    endtask

    // Mostly well-formed allocations and frees of owned runs, with some noise.
    task automatic queue_random_batch(input int count);
        int n;
        int pick;
        int k;
        int i;
        int hit;
        int size;
        int owner;
        for (n = 0; n < count; n++) begin
            pick  = $urandom_range(0, 99);
            size  = $urandom_range(1, 64);
            owner = $urandom_range(1, 255);
            if (pick < 45) begin
                k = $urandom_range(0, 99);
                if (k < 4)
                    size = $urandom_range(0, 1) ? 0 : $urandom_range(UNITS + 1, 2047);
                else if (k < 10)
                    size = $urandom_range(65, UNITS);
                else if (k < 13)
                    owner = 0;
                queue_request(FUNC_ALLOC, size, owner, $urandom_range(0, UNITS - 1));
            end else if (pick < 90) begin
                k   = $urandom_range(0, UNITS - 1);
                hit = -1;
                for (i = 0; i < UNITS && hit < 0; i++)
                    if (unit_owner[(k + i) % UNITS] != 0)
                        hit = (k + i) % UNITS;
                if (hit < 0)
                    hit = k;
                else if ($urandom_range(0, 1))
                    while (hit > 0 && unit_owner[hit - 1] == unit_owner[hit])
                        hit--;
                queue_request(FUNC_FREE, $urandom_range(0, 2047), owner, hit);
            end else begin
                queue_request(FUNC_FREE, $urandom_range(0, 2047), $urandom_range(0, 255),
                              $urandom_range(0, UNITS - 1));
            end
        end
    endtask

    task automatic wait_idle();
        while (!(request_queue.size() == 0 && issued_count == answered_count))
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_run_length(input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        run_length  = value;
    endtask

    // Request driver.
    always @(posedge aclk) begin : drive_proc
        logic [S_TDATA_W-1:0] word;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_replies.push_back(apply_request(on_bus));
            if (s_tvalid && !s_tready) begin
                // Hold the item until it is taken.
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (request_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (stall_enable && $urandom_range(0, 3) == 0) begin
                send_gap = $urandom_range(0, 5);
                s_tvalid <= 1'b0;
            end else begin
                on_bus = request_queue.pop_front();
                issued_count++;
                word = '0;
                word[S_SIZE_LSB  +: SIZE_W]     = on_bus.request_size;
                word[S_OWNER_LSB +: OWNER_ID_W] = on_bus.owner_id;
                word[S_ADDR_LSB  +: ADDR_W]     = on_bus.free_address;
                s_tvalid <= 1'b1;
                s_tdata  <= word;
                s_tuser  <= on_bus.func;
            end
        end
    end

    // Result side back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else if (stall_enable && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor and watchdog.
    always @(posedge aclk) begin : check_proc
        alloc_result_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                $error("result item with none expected: status %0d data %h", m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = expected_replies.pop_front();
                answered_count++;
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatches++;
                end
                if (m_tdata[M_START_LSB +: START_W] !== want.start_unit) begin
                    $error("start_unit: expected %0d, got %0d", want.start_unit,
                           m_tdata[M_START_LSB +: START_W]);
                    mismatches++;
                end
                if (m_tdata[M_FREE_LSB +: FREE_W] !== want.free_units) begin
                    $error("free_units: expected %0d, got %0d", want.free_units,
                           m_tdata[M_FREE_LSB +: FREE_W]);
                    mismatches++;
                end
                if (m_tdata[M_RES_LSB +: RES_W] !== want.resident_processes) begin
                    $error("resident_processes: expected %0d, got %0d",
                           want.resident_processes, m_tdata[M_RES_LSB +: RES_W]);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus_proc
        int batch;
        logic [CFG_W-1:0] setting;
        foreach (unit_owner[i])
            unit_owner[i] = '0;
        used_count = 0;
        run_length = UPP_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Corner cases with the reset run length: bad sizes, owner zero, frees
        // of unowned units, a full memory, a clipped free and a partly owned free.
        queue_request(FUNC_ALLOC, 0, 5, 0);
        queue_request(FUNC_ALLOC, UNITS + 1, 5, 0);
        queue_request(FUNC_ALLOC, 2047, 255, 1023);
        queue_request(FUNC_ALLOC, 10, 0, 0);
        queue_request(FUNC_FREE, 2047, 255, 0);
        queue_request(FUNC_FREE, 0, 0, 1023);
        queue_request(FUNC_ALLOC, 1, 1, 0);
        queue_request(FUNC_ALLOC, 5, 255, 0);
        queue_request(FUNC_ALLOC, UNITS, 7, 0);
        queue_request(FUNC_ALLOC, UNITS - 6, 3, 0);
        queue_request(FUNC_ALLOC, 1, 4, 0);
        queue_request(FUNC_FREE, 0, 1, 1023);
        queue_request(FUNC_FREE, 0, 1, 0);
        queue_request(FUNC_FREE, 0, 1, 500);
        queue_request(FUNC_ALLOC, 64, 2, 1023);
        queue_request(FUNC_FREE, 0, 1, 520);
        queue_request(FUNC_FREE, 0, 1, 490);
        queue_request(FUNC_ALLOC, 60, 9, 0);
        queue_request(FUNC_ALLOC, 1, 10, 0);
        wait_idle();

        // Run length of UNITS: whole-memory frees and a clipped free at the top.
        write_run_length(CFG_W'(UNITS));
        queue_request(FUNC_FREE, 0, 1, 0);
        queue_request(FUNC_ALLOC, UNITS, 200, 0);
        queue_request(FUNC_FREE, 0, 1, 1000);
        queue_request(FUNC_ALLOC, 24, 3, 0);
        queue_request(FUNC_FREE, 0, 1, 0);
        wait_idle();

        for (batch = 0; batch < BATCH_COUNT; batch++) begin
            case (batch % 8)
                0: setting = CFG_W'(1);
                1: setting = '0;
                2: setting = '1;
                3: setting = CFG_W'(17);
                4: setting = CFG_W'(UNITS);
                5: setting = CFG_W'($urandom_range(1, UNITS));
                6: setting = UPP_RESET;
                default: setting = CFG_W'($urandom_range(2, 40));
            endcase
            write_run_length(setting);
            // Some batches run without stalls, and the last ones never stall.
            stall_enable = (batch < BATCH_COUNT - 3) && ($urandom_range(0, 4) != 0);
            queue_random_batch(BATCH_ITEMS);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
